// ===== rtl/constant_tensor_pad_address_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the constant tensor pad address generator
// Concurrent assertion wrappers that compile to nothing when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef CONSTANT_TENSOR_PAD_ADDRESS_GENERATOR_MACROS_SVH
`define CONSTANT_TENSOR_PAD_ADDRESS_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define CTPAG_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");
`define CTPAG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define CTPAG_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define CTPAG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/ctpag_pkg.sv =====
// ----------------------------------------------------------------------------
// ctpag_pkg
// Shared constants and types of the constant tensor pad address generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctpag_pkg;

	localparam int MAX_RANK_DEF   = 6;
	localparam int DIM_BITS_DEF   = 16;
	localparam int INDEX_BITS_DEF = 32;

	localparam int RANK_BITS      = 3;
	localparam int PAD_BITS       = 64;
	localparam int SETUP_BITS     = 48;
	localparam int NUM_DIM_REGS   = 6;
	localparam int CFG_DATA_BITS  = 64;
	localparam int CFG_INDEX_BITS = 3;
	localparam int OUT_INDEX_BITS = 32;
	localparam int IN_DATA_BITS   = 8;
	localparam int OUT_DATA_BITS  = PAD_BITS + 2 * OUT_INDEX_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_RANK      = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PAD_VALUE = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DIM0      = 3'd2;

	typedef struct packed {
		logic pad;
		logic at_end;
	} dim_status_t;

endpackage

// ===== rtl/constant_tensor_pad_address_generator.sv =====
// A word accepted on the s side appears on the m side in the next cycle.
// Throughput: one word per cycle while m_tready is high; the next position is
// combinational from coordinate and count registers; one output register.
// Reset clears the coordinates, both counts and the output valid, and sets
// rank to 1, pad value to 0 and every dimension to size 1 with no padding.
// ----------------------------------------------------------------------------
// constant_tensor_pad_address_generator
// Walks a constant-padded tensor in row-major order, one element per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "constant_tensor_pad_address_generator_macros.svh"

module constant_tensor_pad_address_generator #(
	parameter int MAX_RANK   = ctpag_pkg::MAX_RANK_DEF,
	parameter int DIM_BITS   = ctpag_pkg::DIM_BITS_DEF,
	parameter int INDEX_BITS = ctpag_pkg::INDEX_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ctpag_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ctpag_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// Bit 0: restart; bits 7:1 zero.
	input  logic [ctpag_pkg::IN_DATA_BITS-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// Bits 63:0 fill_value, 95:64 src_index, 127:96 out_index.
	output logic [ctpag_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	// Bit 0: is_pad.
	output logic                                 m_tuser,
	output logic                                 m_tlast
);

	localparam int CW   = DIM_BITS + 2;
	localparam int SB   = ctpag_pkg::SETUP_BITS;
	localparam int EXTW = (3 * DIM_BITS > SB) ? 3 * DIM_BITS : SB;
	localparam int OIB  = ctpag_pkg::OUT_INDEX_BITS;

	logic [ctpag_pkg::RANK_BITS-1:0] rank_q;
	logic [ctpag_pkg::PAD_BITS-1:0]  pad_value_q;
	logic [SB-1:0]                   dim_setup [MAX_RANK];

	logic [CW-1:0]         coord_q   [MAX_RANK];
	logic [CW-1:0]         coord_eff [MAX_RANK];
	logic [CW-1:0]         coord_nx  [MAX_RANK];
	logic [INDEX_BITS-1:0] src_cnt_q;
	logic [INDEX_BITS-1:0] out_cnt_q;
	logic [INDEX_BITS-1:0] src_eff;
	logic [INDEX_BITS-1:0] out_eff;

	ctpag_pkg::dim_status_t dim_st [MAX_RANK];
	logic [MAX_RANK-1:0]    used;
	logic [MAX_RANK-1:0]    carry_in;
	logic [MAX_RANK-1:0]    pad_vec;
	logic                   restart;
	logic                   pad_c;
	logic                   last_c;
	logic                   in_acc;

	logic                   out_valid_q;
	logic                   is_pad_s1;
	logic                   last_s1;
	logic [ctpag_pkg::PAD_BITS-1:0] fill_s1;
	logic [OIB-1:0]         src_s1;
	logic [OIB-1:0]         out_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q      <= ctpag_pkg::RANK_BITS'(1);
			pad_value_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == ctpag_pkg::REG_RANK) begin
				rank_q <= cfg_data[ctpag_pkg::RANK_BITS-1:0];
			end
			if (cfg_index == ctpag_pkg::REG_PAD_VALUE) begin
				pad_value_q <= cfg_data[ctpag_pkg::PAD_BITS-1:0];
			end
		end
	end

	assign restart = s_tdata[0];
	assign in_acc  = s_tvalid && s_tready;

	for (genvar d = 0; d < MAX_RANK; d++) begin : g_dim
		logic [EXTW-1:0] setup_ext;

		if (d < ctpag_pkg::NUM_DIM_REGS) begin : g_reg
			logic [SB-1:0] setup_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					setup_q <= SB'(1);
				end else if (cfg_we &&
						cfg_index == ctpag_pkg::CFG_INDEX_BITS'(int'(ctpag_pkg::REG_DIM0) + d)) begin
					setup_q <= cfg_data[SB-1:0];
				end
			end
			assign dim_setup[d] = setup_q;
		end else begin : g_fixed
			assign dim_setup[d] = SB'(1);
		end

		assign setup_ext    = EXTW'(dim_setup[d]);
		assign used[d]      = (d == 0) || (int'(rank_q) > d);
		assign coord_eff[d] = restart ? '0 : coord_q[d];
		assign pad_vec[d]   = dim_st[d].pad;

		ctpag_dim #(
			.DIM_BITS(DIM_BITS)
		) u_dim (
			.size      (setup_ext[DIM_BITS-1:0]),
			.pad_front (setup_ext[2*DIM_BITS-1:DIM_BITS]),
			.after     (setup_ext[3*DIM_BITS-1:2*DIM_BITS]),
			.coord     (coord_eff[d]),
			.used      (used[d]),
			.advance   (used[d] && carry_in[d]),
			.status    (dim_st[d]),
			.coord_next(coord_nx[d])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				coord_q[d] <= '0;
			end else if (in_acc) begin
				coord_q[d] <= last_c ? '0 : coord_nx[d];
			end
		end
	end

	always_comb begin
		carry_in[MAX_RANK-1] = 1'b1;
		for (int d = MAX_RANK - 2; d >= 0; d--) begin
			carry_in[d] = carry_in[d+1] && (!used[d+1] || dim_st[d+1].at_end);
		end
	end

	assign last_c  = carry_in[0] && dim_st[0].at_end;
	assign pad_c   = |pad_vec;
	assign src_eff = restart ? '0 : src_cnt_q;
	assign out_eff = restart ? '0 : out_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cnt_q <= '0;
			out_cnt_q <= '0;
		end else if (in_acc) begin
			if (last_c) begin
				src_cnt_q <= '0;
				out_cnt_q <= '0;
			end else begin
				src_cnt_q <= src_eff + INDEX_BITS'(!pad_c);
				out_cnt_q <= out_eff + INDEX_BITS'(1);
			end
		end
	end

	assign s_tready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			is_pad_s1 <= pad_c;
			last_s1   <= last_c;
			fill_s1   <= pad_c ? pad_value_q : '0;
			src_s1    <= OIB'(src_eff);
			out_s1    <= OIB'(out_eff);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_s1, src_s1, fill_s1};
	assign m_tuser  = is_pad_s1;
	assign m_tlast  = last_s1;

	`CTPAG_ASSERT_NEXT(a_acc_gives_word, clk, arst_n, in_acc, m_tvalid)
	`CTPAG_ASSERT_NEXT(a_last_clears, clk, arst_n, in_acc && last_c,
		src_cnt_q == '0 && out_cnt_q == '0)
	`CTPAG_ASSERT_IMPLY(a_fill_zero, clk, arst_n, m_tvalid && !m_tuser,
		m_tdata[ctpag_pkg::PAD_BITS-1:0] == '0)

endmodule

// ===== rtl/ctpag_dim.sv =====
// ----------------------------------------------------------------------------
// ctpag_dim
// One dimension of the padded walk: padding test, end test and next coordinate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctpag_dim #(
	parameter int DIM_BITS = ctpag_pkg::DIM_BITS_DEF
) (
	input  logic [DIM_BITS-1:0]   size,
	input  logic [DIM_BITS-1:0]   pad_front,
	input  logic [DIM_BITS-1:0]   after,
	input  logic [DIM_BITS+1:0]   coord,
	input  logic                  used,
	input  logic                  advance,
	output ctpag_pkg::dim_status_t status,
	output logic [DIM_BITS+1:0]   coord_next
);

	localparam int CW = DIM_BITS + 2;

	logic [CW-1:0] hi;
	logic [CW-1:0] extent;
	logic [CW:0]   coord_inc;

	assign hi        = CW'(pad_front) + CW'(size);
	assign extent    = hi + CW'(after);
	assign coord_inc = (CW+1)'(coord) + (CW+1)'(1);

	assign status.pad    = used && ((coord < CW'(pad_front)) || (coord >= hi));
	assign status.at_end = coord_inc >= (CW+1)'(extent);

	always_comb begin
		if (advance) begin
			coord_next = status.at_end ? '0 : coord_inc[CW-1:0];
		end else begin
			coord_next = coord;
		end
	end

endmodule
